FILE: design/environment_sample_filter_defines.svh
`ifndef ENVIRONMENT_SAMPLE_FILTER_DEFINES_SVH
`define ENVIRONMENT_SAMPLE_FILTER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define ESF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("environment_sample_filter check failed");

// next-cycle implication
`define ESF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("environment_sample_filter check failed");

`endif

FILE: design/esf_pkg.sv
package esf_pkg;

    localparam int GUARD_BITS = 4;

    localparam int TEMP_W     = 16;
    localparam int PRES_W     = 18;
    localparam int HUM_W      = 16;
    localparam int TOFF_W     = 15;
    localparam int POFF_W     = 16;
    localparam int HOFF_W     = 15;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 16;
    localparam int CAPS_W     = 3;
    localparam int NF_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // accumulators carry GUARD_BITS fraction bits
    localparam int T_ACC_W = TEMP_W + GUARD_BITS;
    localparam int P_ACC_W = PRES_W + 1 + GUARD_BITS;
    localparam int H_ACC_W = HUM_W + GUARD_BITS;

    // range-check widths, wide enough for raw value plus offset
    localparam int TC_W = TEMP_W + 2;
    localparam int PC_W = PRES_W + 2;
    localparam int HC_W = HUM_W + 2;

    localparam logic signed [TC_W-1:0] TEMP_MIN = TC_W'(-4000);
    localparam logic signed [TC_W-1:0] TEMP_MAX = TC_W'(8500);
    localparam logic signed [PC_W-1:0] PRES_MIN = PC_W'(30000);
    localparam logic signed [PC_W-1:0] PRES_MAX = PC_W'(110000);
    localparam logic signed [HC_W-1:0] HUM_MIN  = HC_W'(0);
    localparam logic signed [HC_W-1:0] HUM_MAX  = HC_W'(10000);

    // bit positions shared by sensor_caps and not_finite_flags
    localparam int CH_TEMP = 0;
    localparam int CH_HUM  = 1;
    localparam int CH_PRES = 2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPS    = 3'd0,
        CFG_TOFF    = 3'd1,
        CFG_POFF    = 3'd2,
        CFG_HOFF    = 3'd3,
        CFG_TIMEOUT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                     cmd;
        logic [TIME_W-1:0]        now_ms;
        logic signed [TEMP_W-1:0] raw_temperature;
        logic [PRES_W-1:0]        raw_pressure;
        logic signed [HUM_W-1:0]  raw_humidity;
        logic                     humidity_present;
        logic [NF_W-1:0]          not_finite_flags;
    } t_in_word;

    typedef struct packed {
        logic                     accepted;
        logic signed [TEMP_W-1:0] filtered_temperature;
        logic [PRES_W-1:0]        filtered_pressure;
        logic signed [HUM_W-1:0]  filtered_humidity;
        logic                     filtered_has_humidity;
        logic                     value_present;
        logic                     is_stale;
        logic [CNT_W-1:0]         rejected_count;
        logic [TIME_W-1:0]        last_good_ms;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_word;

    function automatic logic sample_ok(
        input logic [CAPS_W-1:0]      caps,
        input logic signed [TC_W-1:0] t,
        input logic signed [PC_W-1:0] p,
        input logic signed [HC_W-1:0] h,
        input logic                   has_h,
        input logic [NF_W-1:0]        nf
    );
        logic t_ok;
        logic p_ok;
        logic h_ok;
        t_ok = caps[CH_TEMP] && !nf[CH_TEMP] && (t >= TEMP_MIN) && (t <= TEMP_MAX);
        p_ok = !caps[CH_PRES] || (!nf[CH_PRES] && (p >= PRES_MIN) && (p <= PRES_MAX));
        if (caps[CH_HUM]) begin
            h_ok = has_h && !nf[CH_HUM] && (h >= HUM_MIN) && (h <= HUM_MAX);
        end else begin
            h_ok = !has_h;
        end
        return t_ok && p_ok && h_ok;
    endfunction

endpackage

FILE: design/esf_if.sv
interface esf_in_if;
    logic               valid;
    logic               ready;
    esf_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esf_out_if;
    logic               valid;
    logic               ready;
    esf_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esf_cfg_if;
    logic               valid;
    logic               ready;
    esf_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/environment_sample_filter.sv
// Environment sample filter: range-checks and offset-calibrates temperature,
// pressure and humidity words, smooths accepted samples with a quarter-weight
// exponential average and returns one result word per input word. Throughput
// is one word per clock while the output is not stalled; each word moves from
// the input register to the result register, and the filter state is updated
// as it does so, so the next word sees it. Configuration writes are always
// taken and must only be issued while no word is in flight.
module environment_sample_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esf_in_if.sink     i_in,
    esf_out_if.source  o_out,
    esf_cfg_if.sink    i_cfg
);

    localparam int GB = esf_pkg::GUARD_BITS;

    // configuration
    logic [esf_pkg::CAPS_W-1:0]        r_caps;
    logic signed [esf_pkg::TOFF_W-1:0] r_toff;
    logic signed [esf_pkg::POFF_W-1:0] r_poff;
    logic signed [esf_pkg::HOFF_W-1:0] r_hoff;
    logic [esf_pkg::TIME_W-1:0]        r_timeout;

    // filter state
    logic signed [esf_pkg::T_ACC_W-1:0] r_t_acc, n_t_acc;
    logic signed [esf_pkg::P_ACC_W-1:0] r_p_acc, n_p_acc;
    logic signed [esf_pkg::H_ACC_W-1:0] r_h_acc, n_h_acc;
    logic                               r_hum_flag, n_hum_flag;
    logic                               r_have, n_have;
    logic [esf_pkg::TIME_W-1:0]         r_last, n_last;
    logic [esf_pkg::CNT_W-1:0]          r_rej, n_rej;

    // pipeline
    logic               r_in_vld, n_in_vld;
    esf_pkg::t_in_word  r_in;
    logic               r_out_vld, n_out_vld;
    esf_pkg::t_out_word r_out, n_out;
    logic               adv;

    // datapath
    logic                                is_sample, has_p, has_h, ok;
    logic signed [esf_pkg::TC_W-1:0]     t_raw, t_cal;
    logic signed [esf_pkg::PC_W-1:0]     p_raw, p_cal;
    logic signed [esf_pkg::HC_W-1:0]     h_raw, h_cal;
    logic signed [esf_pkg::T_ACC_W-1:0]  t_load, t_ema;
    logic signed [esf_pkg::P_ACC_W-1:0]  p_load, p_ema;
    logic signed [esf_pkg::H_ACC_W-1:0]  h_load, h_ema;
    logic signed [esf_pkg::T_ACC_W:0]    t_diff, t_step;
    logic signed [esf_pkg::P_ACC_W:0]    p_diff, p_step;
    logic signed [esf_pkg::H_ACC_W:0]    h_diff, h_step;
    logic [esf_pkg::TIME_W-1:0]          age;

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;
    assign n_in_vld   = (i_in.valid && i_in.ready) || (r_in_vld && !adv);
    assign n_out_vld  = adv || (r_out_vld && !o_out.ready);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        is_sample = (r_in.cmd == esf_pkg::CMD_SAMPLE);
        has_p     = r_caps[esf_pkg::CH_PRES];
        has_h     = r_in.humidity_present;

        t_raw = esf_pkg::TC_W'($signed(r_in.raw_temperature));
        p_raw = $signed(esf_pkg::PC_W'(r_in.raw_pressure));
        h_raw = esf_pkg::HC_W'($signed(r_in.raw_humidity));

        t_cal = t_raw + esf_pkg::TC_W'(r_toff);
        p_cal = has_p ? p_raw + esf_pkg::PC_W'(r_poff) : '0;
        h_cal = has_h ? h_raw + esf_pkg::HC_W'(r_hoff) : '0;

        ok = is_sample
            && esf_pkg::sample_ok(r_caps, t_raw, p_raw, h_raw, has_h, r_in.not_finite_flags)
            && esf_pkg::sample_ok(r_caps, t_cal, p_cal, h_cal, has_h, r_in.not_finite_flags);

        t_load = {t_cal[esf_pkg::TEMP_W-1:0], {GB{1'b0}}};
        p_load = {p_cal[esf_pkg::PRES_W:0], {GB{1'b0}}};
        h_load = {h_cal[esf_pkg::HUM_W-1:0], {GB{1'b0}}};

        t_diff = {t_load[esf_pkg::T_ACC_W-1], t_load} - {r_t_acc[esf_pkg::T_ACC_W-1], r_t_acc};
        p_diff = {p_load[esf_pkg::P_ACC_W-1], p_load} - {r_p_acc[esf_pkg::P_ACC_W-1], r_p_acc};
        h_diff = {h_load[esf_pkg::H_ACC_W-1], h_load} - {r_h_acc[esf_pkg::H_ACC_W-1], r_h_acc};
        t_step = t_diff >>> 2;
        p_step = p_diff >>> 2;
        h_step = h_diff >>> 2;
        t_ema  = r_t_acc + t_step[esf_pkg::T_ACC_W-1:0];
        p_ema  = r_p_acc + p_step[esf_pkg::P_ACC_W-1:0];
        h_ema  = r_h_acc + h_step[esf_pkg::H_ACC_W-1:0];

        n_t_acc    = r_t_acc;
        n_p_acc    = r_p_acc;
        n_h_acc    = r_h_acc;
        n_hum_flag = r_hum_flag;
        n_have     = r_have;
        n_last     = r_last;
        n_rej      = r_rej;
        if (ok) begin
            n_t_acc    = r_have ? t_ema : t_load;
            n_p_acc    = !has_p ? '0 : (r_have ? p_ema : p_load);
            n_h_acc    = !has_h ? '0 : (r_have ? h_ema : h_load);
            n_hum_flag = has_h;
            n_have     = 1'b1;
            n_last     = r_in.now_ms;
        end else if (is_sample && (r_rej != '1)) begin
            n_rej = r_rej + 1'b1;
        end

        age = r_in.now_ms - n_last;

        n_out.accepted              = ok;
        n_out.filtered_temperature  = n_t_acc[GB +: esf_pkg::TEMP_W];
        n_out.filtered_pressure     = n_p_acc[GB +: esf_pkg::PRES_W];
        n_out.filtered_humidity     = n_h_acc[GB +: esf_pkg::HUM_W];
        n_out.filtered_has_humidity = n_hum_flag;
        n_out.value_present         = n_have;
        n_out.is_stale              = n_have && (age > r_timeout);
        n_out.rejected_count        = n_rej;
        n_out.last_good_ms          = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_caps     <= '0;
            r_toff     <= '0;
            r_poff     <= '0;
            r_hoff     <= '0;
            r_timeout  <= '0;
            r_t_acc    <= '0;
            r_p_acc    <= '0;
            r_h_acc    <= '0;
            r_hum_flag <= 1'b0;
            r_have     <= 1'b0;
            r_last     <= '0;
            r_rej      <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (adv) begin
                r_t_acc    <= n_t_acc;
                r_p_acc    <= n_p_acc;
                r_h_acc    <= n_h_acc;
                r_hum_flag <= n_hum_flag;
                r_have     <= n_have;
                r_last     <= n_last;
                r_rej      <= n_rej;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (esf_pkg::t_cfg_idx'(i_cfg.data.idx))
                    esf_pkg::CFG_CAPS: begin
                        r_caps <= i_cfg.data.wdata[esf_pkg::CAPS_W-1:0];
                    end
                    esf_pkg::CFG_TOFF: begin
                        r_toff <= i_cfg.data.wdata[esf_pkg::TOFF_W-1:0];
                    end
                    esf_pkg::CFG_POFF: begin
                        r_poff <= i_cfg.data.wdata[esf_pkg::POFF_W-1:0];
                    end
                    esf_pkg::CFG_HOFF: begin
                        r_hoff <= i_cfg.data.wdata[esf_pkg::HOFF_W-1:0];
                    end
                    esf_pkg::CFG_TIMEOUT: begin
                        r_timeout <= i_cfg.data.wdata[esf_pkg::TIME_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: design/esf_checker.sv
`include "environment_sample_filter_defines.svh"

module esf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input esf_pkg::t_out_word i_out_data
);

    // a stalled result word holds
    `ESF_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    `ESF_ASSERT_IMP(a_acc_present, i_out_valid && i_out_data.accepted, i_out_data.value_present)

    `ESF_ASSERT_IMP(a_acc_fresh, i_out_valid && i_out_data.accepted, !i_out_data.is_stale)

    `ESF_ASSERT_IMP(a_stale_present, i_out_valid && i_out_data.is_stale, i_out_data.value_present)

    // humidity reads zero unless the filter carries it
    `ESF_ASSERT_IMP(a_hum_zero, i_out_valid && !i_out_data.filtered_has_humidity, i_out_data.filtered_humidity == '0)

endmodule

bind environment_sample_filter esf_checker u_esf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
